[hw/rtl/edd_pkg.sv]
// Shared constants and types for the escape doubling deframer.
package edd_pkg;

    localparam int MAX_PACKET = 512;
    localparam int CNT_W      = $clog2(MAX_PACKET + 1);

    localparam int BYTE_W   = 8;
    localparam int INDEX_W  = 9;
    localparam int LENGTH_W = 10;

    localparam logic [BYTE_W-1:0] FRAME_RESET = 8'd112;

    typedef struct packed {
        logic                is_end;
        logic [BYTE_W-1:0]   payload_byte;
        logic [INDEX_W-1:0]  byte_index;
        logic [LENGTH_W-1:0] packet_length;
        logic                truncated;
    } t_result;

endpackage

[hw/rtl/edd_decode.sv]
// Escape and packet state, and the per-byte result decode.
module edd_decode
    import edd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [BYTE_W-1:0] i_cfg_data,
    input  logic              i_accept,
    input  logic [BYTE_W-1:0] i_rx_byte,
    output logic              o_res_valid,
    output t_result           o_res
);

    logic [BYTE_W-1:0] r_frame;
    logic              r_esc;
    logic [CNT_W-1:0]  r_count;
    logic              r_ovf;

    logic              n_esc;
    logic [CNT_W-1:0]  n_count;
    logic              n_ovf;
    logic              hit;
    logic              full;

    assign hit  = (i_rx_byte == r_frame);
    assign full = (r_count >= CNT_W'(MAX_PACKET));

    always_comb begin
        n_esc       = r_esc;
        n_count     = r_count;
        n_ovf       = r_ovf;
        o_res_valid = 1'b0;
        o_res       = '0;
        if (r_esc && !hit) begin
            n_esc               = 1'b0;
            o_res_valid         = 1'b1;
            o_res.is_end        = 1'b1;
            o_res.packet_length = LENGTH_W'(r_count);
            o_res.truncated     = r_ovf;
            n_count             = '0;
            n_ovf               = 1'b0;
        end else if (!r_esc && hit) begin
            n_esc = 1'b1;
        end else begin
            // literal byte, including a doubled flag
            n_esc = 1'b0;
            if (full) begin
                n_ovf = 1'b1;
            end else begin
                o_res_valid        = 1'b1;
                o_res.payload_byte = i_rx_byte;
                o_res.byte_index   = INDEX_W'(r_count);
                n_count            = r_count + CNT_W'(1);
            end
        end
        if (!i_accept) begin
            o_res_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame <= FRAME_RESET;
            r_esc   <= 1'b0;
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_frame <= i_cfg_data;
            end
            if (i_accept) begin
                r_esc   <= n_esc;
                r_count <= n_count;
                r_ovf   <= n_ovf;
            end
        end
    end

endmodule

[hw/rtl/edd_skid.sv]
// Result register with a skid stage that holds one more result while the output stalls.
module edd_skid
    import edd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_ready,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_data
);

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;

    assign o_ready = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || i_ready) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_push;
            end
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_ready) begin
            r_out <= r_skid_valid ? r_skid : i_data;
        end else if (i_push) begin
            r_skid <= i_data;
        end
    end

endmodule

[hw/rtl/escape_doubling_deframer.sv]
// Top level of the escape doubling deframer.
//
// Usage: one received serial byte per transaction on the rx channel
// (i_rx_valid / o_rx_ready / i_rx_byte). Each byte produces zero or one
// result transaction on the result channel (o_res_valid / i_res_ready):
// a payload byte with its index in the packet, or an end-of-packet mark
// with the stored length and a truncation flag. A flag byte followed by
// itself is one literal flag byte; a flag byte followed by anything else
// ends the packet and that byte is discarded. Bytes beyond MAX_PACKET are
// dropped and flagged at the end.
// Throughput: one byte per cycle while o_rx_ready is high, with a single
// decode stage. Stall: a two-entry result register (output plus skid) lets
// one more byte in while a result waits; o_rx_ready drops once the skid is
// full. Reset (synchronous, active low) clears escape, count and overflow
// state, empties the result stage and sets the flag byte to 112. The flag
// byte register is written by i_cfg_we / i_cfg_data; the user must do so
// only while the block is idle, which the block itself does not enforce.
module escape_doubling_deframer
    import edd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [BYTE_W-1:0]   i_cfg_data,
    input  logic                i_rx_valid,
    output logic                o_rx_ready,
    input  logic [BYTE_W-1:0]   i_rx_byte,
    output logic                o_res_valid,
    input  logic                i_res_ready,
    output logic                o_is_end,
    output logic [BYTE_W-1:0]   o_payload_byte,
    output logic [INDEX_W-1:0]  o_byte_index,
    output logic [LENGTH_W-1:0] o_packet_length,
    output logic                o_truncated
);

    logic    accept;
    logic    push;
    t_result dec_res;
    t_result out_res;

    assign accept = i_rx_valid && o_rx_ready;

    edd_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_rx_byte   (i_rx_byte),
        .o_res_valid (push),
        .o_res       (dec_res)
    );

    edd_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (dec_res),
        .o_ready (o_rx_ready),
        .o_valid (o_res_valid),
        .i_ready (i_res_ready),
        .o_data  (out_res)
    );

    assign o_is_end        = out_res.is_end;
    assign o_payload_byte  = out_res.payload_byte;
    assign o_byte_index    = out_res.byte_index;
    assign o_packet_length = out_res.packet_length;
    assign o_truncated     = out_res.truncated;

endmodule

[tb/sv/tb_escape_doubling_deframer.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the escape doubling deframer: directed and random framed traffic, noise, scoreboard.

module tb_escape_doubling_deframer
    import edd_pkg::*;
;

    class deframe_check;
        logic [BYTE_W-1:0] flag;
        bit                esc_open;
        int                stored;
        bit                dropped;
        t_result           pending_results[$];
        int                errors;

        function new();
            flag     = FRAME_RESET;
            esc_open = 1'b0;
            stored   = 0;
            dropped  = 1'b0;
            errors   = 0;
        endfunction

        function void set_flag(logic [BYTE_W-1:0] v);
            flag = v;
        endfunction

        function int outstanding();
            return pending_results.size();
        endfunction

        // Decode one accepted rx transaction and queue the result it causes, if any.
        function void take_byte(logic [BYTE_W-1:0] c);
            t_result r;
            r = '0;
            if (esc_open) begin
                esc_open = 1'b0;
                if (c != flag) begin
                    r.is_end        = 1'b1;
                    r.packet_length = stored[LENGTH_W-1:0];
                    r.truncated     = dropped;
                    pending_results.push_back(r);
                    stored  = 0;
                    dropped = 1'b0;
                    return;
                end
            end else if (c == flag) begin
                esc_open = 1'b1;
                return;
            end
            if (stored >= MAX_PACKET) begin
                dropped = 1'b1;
                return;
            end
            r.payload_byte = c;
            r.byte_index   = stored[INDEX_W-1:0];
            pending_results.push_back(r);
            stored++;
        endfunction

        function void match_result(t_result got);
            t_result want;
            if (pending_results.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: unexpected result end=%0b data=%02h idx=%0d len=%0d trunc=%0b",
                             $time, got.is_end, got.payload_byte, got.byte_index,
                             got.packet_length, got.truncated);
                return;
            end
            want = pending_results.pop_front();
            if (got.is_end != want.is_end || got.payload_byte != want.payload_byte ||
                got.byte_index != want.byte_index ||
                got.packet_length != want.packet_length ||
                got.truncated != want.truncated) begin
                errors++;
                if (errors <= 10) begin
                    $display("%0t: mismatch exp end=%0b data=%02h idx=%0d len=%0d trunc=%0b",
                             $time, want.is_end, want.payload_byte, want.byte_index,
                             want.packet_length, want.truncated);
                    $display("%0t:          got end=%0b data=%02h idx=%0d len=%0d trunc=%0b",
                             $time, got.is_end, got.payload_byte, got.byte_index,
                             got.packet_length, got.truncated);
                end
            end
        endfunction
    endclass

    typedef enum {SINK_ALWAYS, SINK_MOSTLY, SINK_PERIODIC, SINK_SPARSE} t_sink_mode;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [BYTE_W-1:0]   i_cfg_data;
    logic                i_rx_valid;
    logic                o_rx_ready;
    logic [BYTE_W-1:0]   i_rx_byte;
    logic                o_res_valid;
    logic                i_res_ready;
    logic                o_is_end;
    logic [BYTE_W-1:0]   o_payload_byte;
    logic [INDEX_W-1:0]  o_byte_index;
    logic [LENGTH_W-1:0] o_packet_length;
    logic                o_truncated;

    deframe_check chk;
    int           items_sent;
    int           burst_left;
    t_sink_mode   sink_mode;
    int           sink_mode_left;
    int           sink_tick;

    escape_doubling_deframer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_rx_valid      (i_rx_valid),
        .o_rx_ready      (o_rx_ready),
        .i_rx_byte       (i_rx_byte),
        .o_res_valid     (o_res_valid),
        .i_res_ready     (i_res_ready),
        .o_is_end        (o_is_end),
        .o_payload_byte  (o_payload_byte),
        .o_byte_index    (o_byte_index),
        .o_packet_length (o_packet_length),
        .o_truncated     (o_truncated)
    );

    always #5 i_clk = ~i_clk;

    // result sink: stall pattern switches between randomly chosen modes
    always @(negedge i_clk) begin
        if (sink_mode_left == 0) begin
            sink_mode      = t_sink_mode'($urandom_range(0, 3));
            sink_mode_left = $urandom_range(50, 300);
        end
        sink_mode_left--;
        sink_tick++;
        case (sink_mode)
            SINK_ALWAYS:   i_res_ready <= 1'b1;
            SINK_MOSTLY:   i_res_ready <= ($urandom_range(0, 3) != 0);
            SINK_PERIODIC: i_res_ready <= (sink_tick % 5 < 3);
            default:       i_res_ready <= ($urandom_range(0, 5) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_res_valid && i_res_ready)
            chk.match_result(t_result'{o_is_end, o_payload_byte, o_byte_index,
                                       o_packet_length, o_truncated});
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        if (burst_left <= 0) begin
            gap = $urandom_range(1, 8);
            @(negedge i_clk);
            i_rx_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                    : $urandom_range(1, 24);
        end
        @(negedge i_clk);
        i_rx_valid <= 1'b1;
        i_rx_byte  <= b;
        @(posedge i_clk);
        while (!o_rx_ready) @(posedge i_clk);
        chk.take_byte(b);
        burst_left--;
        items_sent++;
    endtask

    // hold off the sender until every expected result is out, then settle
    task automatic drain();
        @(negedge i_clk);
        i_rx_valid <= 1'b0;
        while (chk.outstanding() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_flag(input logic [BYTE_W-1:0] v);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        chk.set_flag(v);
    endtask

    function automatic logic [BYTE_W-1:0] plain_byte();
        logic [BYTE_W-1:0] b;
        b = BYTE_W'($urandom_range(0, 255));
        while (b == chk.flag) b = BYTE_W'($urandom_range(0, 255));
        return b;
    endfunction

    // well-formed packet: payload with doubled flags, then flag + terminator
    task automatic send_packet(input int len, input int flag_pct);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 99) < flag_pct) begin
                send_byte(chk.flag);
                send_byte(chk.flag);
            end else begin
                send_byte(plain_byte());
            end
        end
        send_byte(chk.flag);
        send_byte(plain_byte());
    endtask

    task automatic send_noise(input int n);
        for (int i = 0; i < n; i++)
            send_byte(($urandom_range(0, 99) < 30) ? chk.flag
                                                   : BYTE_W'($urandom_range(0, 255)));
    endtask

    initial begin
        int phase;
        int phase_end;
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_data  = '0;
        i_rx_valid  = 1'b0;
        i_rx_byte   = '0;
        i_res_ready = 1'b0;
        items_sent  = 0;
        burst_left  = 0;
        chk = new();
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset flag value, literal flag, end, empty packet
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(FRAME_RESET);
        send_byte(FRAME_RESET);
        send_byte(FRAME_RESET);
        send_byte(8'h55);
        send_byte(FRAME_RESET);
        send_byte(8'h01);
        // open escape, change flag, old flag now ends the packet
        send_byte(8'hA5);
        send_byte(FRAME_RESET);
        drain();
        write_flag(8'h3C);
        send_byte(FRAME_RESET);
        // open escape, change flag, new flag is a literal
        send_byte(8'h3C);
        drain();
        write_flag(8'hC3);
        send_byte(8'hC3);
        send_byte(8'hC3);
        send_byte(8'h3C);

        phase = 0;
        while (items_sent < 1970) begin
            drain();
            case (phase)
                0:       write_flag(8'h00);
                1:       write_flag(8'hFF);
                default: write_flag(BYTE_W'($urandom_range(0, 255)));
            endcase
            if (phase == 1)
                send_packet(MAX_PACKET, 5);
            if (phase == 3)
                send_packet(MAX_PACKET + $urandom_range(1, 20), 10);
            phase_end = items_sent + $urandom_range(80, 200);
            while (items_sent < phase_end) begin
                if ($urandom_range(0, 99) < 85)
                    send_packet($urandom_range(0, 12), $urandom_range(0, 30));
                else
                    send_noise($urandom_range(1, 10));
            end
            phase++;
        end

        drain();
        if (chk.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
